FILE: sv/cobs_fd_pkg.sv
// cobs_fd_pkg: shared types and constants of the cobs frame decoder
// no dependencies; compiled before every other file of the block

package cobs_fd_pkg;

	localparam int COUNT_WIDTH_DEF = 16;
	localparam int LIMIT_WIDTH     = 16;
	localparam int OUT_COUNT_WIDTH = 16;
	localparam int BYTE_WIDTH      = 8;

	localparam logic [BYTE_WIDTH-1:0]  CODE_MAX       = 8'hFF;
	localparam logic [BYTE_WIDTH-1:0]  CODE_ONE       = 8'h01;
	localparam logic [LIMIT_WIDTH-1:0] MAX_OUT_RESET  = 16'hFFFF;

	typedef enum logic [1:0] {
		ERR_NONE  = 2'd0,
		ERR_LIMIT = 2'd1,
		ERR_TRUNC = 2'd2
	} err_t;

	// classified word handed from front to back
	typedef struct packed {
		logic                  want_emit;
		logic [BYTE_WIDTH-1:0] data;
		logic                  last;
		logic                  owed;
	} cls_word_t;

endpackage

FILE: sv/cobs_fd_if.sv
// cobs_fd_if: valid/ready channel interfaces of the cobs frame decoder
// depends on cobs_fd_pkg

interface cobs_fd_enc_if;
	import cobs_fd_pkg::*;
	logic                  valid;
	logic                  ready;
	logic [BYTE_WIDTH-1:0] encoded_byte;
	logic                  frame_last;

	modport source (output valid, encoded_byte, frame_last, input ready);
	modport sink   (input valid, encoded_byte, frame_last, output ready);
endinterface

interface cobs_fd_dec_if;
	import cobs_fd_pkg::*;
	logic                       valid;
	logic                       ready;
	logic                       data_valid;
	logic [BYTE_WIDTH-1:0]      data_byte;
	logic                       frame_done;
	logic [OUT_COUNT_WIDTH-1:0] decoded_count;
	logic [1:0]                 error_code;

	modport source (output valid, data_valid, data_byte, frame_done, decoded_count,
		error_code, input ready);
	modport sink   (input valid, data_valid, data_byte, frame_done, decoded_count,
		error_code, output ready);
endinterface

interface cobs_fd_cfg_if;
	import cobs_fd_pkg::*;
	logic                   valid;
	logic                   ready;
	logic [LIMIT_WIDTH-1:0] max_output_bytes;

	modport source (output valid, max_output_bytes, input ready);
	modport sink   (input valid, max_output_bytes, output ready);
endinterface

FILE: sv/cobs_fd_front.sv
// cobs_fd_front: accepts encoded bytes and classifies them as code or data
// depends on cobs_fd_pkg and cobs_fd_if

module cobs_fd_front (
	input  logic                   clk,
	input  logic                   arst_n,
	cobs_fd_enc_if.sink            enc,
	input  logic                   q_full,
	output logic                   push,
	output cobs_fd_pkg::cls_word_t push_word
);
	import cobs_fd_pkg::*;

	logic [BYTE_WIDTH-1:0] rem_q;
	logic                  prev_max_q;
	logic                  first_q;
	logic [BYTE_WIDTH-1:0] rem_n;
	logic                  prev_max_n;
	logic                  first_n;

	assign enc.ready = !q_full;
	assign push      = enc.valid && !q_full;

	always_comb begin
		rem_n      = rem_q;
		prev_max_n = prev_max_q;
		first_n    = first_q;
		push_word.last = enc.frame_last;
		if (rem_q == '0) begin
			// code byte: restored zero before every block but the first and those that follow a full (0xFF) block
			push_word.want_emit = !first_q && !prev_max_q;
			push_word.data      = '0;
			first_n    = 1'b0;
			prev_max_n = (enc.encoded_byte == CODE_MAX);
			rem_n      = (enc.encoded_byte > CODE_ONE) ? enc.encoded_byte - CODE_ONE : '0;
		end else begin
			push_word.want_emit = 1'b1;
			push_word.data      = enc.encoded_byte;
			rem_n = rem_q - CODE_ONE;
		end
		push_word.owed = (rem_n != '0);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rem_q      <= '0;
			prev_max_q <= 1'b0;
			first_q    <= 1'b1;
		end else if (push) begin
			if (enc.frame_last) begin
				rem_q      <= '0;
				prev_max_q <= 1'b0;
				first_q    <= 1'b1;
			end else begin
				rem_q      <= rem_n;
				prev_max_q <= prev_max_n;
				first_q    <= first_n;
			end
		end
	end

endmodule

FILE: sv/cobs_fd_queue.sv
// cobs_fd_queue: two-entry queue of classified words between front and back
// depends on cobs_fd_pkg

module cobs_fd_queue (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   push,
	input  cobs_fd_pkg::cls_word_t push_word,
	input  logic                   pop,
	output cobs_fd_pkg::cls_word_t pop_word,
	output logic                   full,
	output logic                   empty
);
	import cobs_fd_pkg::*;

	cls_word_t  mem_q [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] fill_q;

	assign full     = (fill_q == 2'd2);
	assign empty    = (fill_q == 2'd0);
	assign pop_word = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_word;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			fill_q   <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			if (push && !pop) begin
				fill_q <= fill_q + 2'd1;
			end else if (pop && !push) begin
				fill_q <= fill_q - 2'd1;
			end
		end
	end

endmodule

FILE: sv/cobs_fd_back.sv
// cobs_fd_back: counts decoded bytes, latches errors, holds the result register
// depends on cobs_fd_pkg and cobs_fd_if

module cobs_fd_back #(
	parameter int COUNT_WIDTH = cobs_fd_pkg::COUNT_WIDTH_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                q_empty,
	input  cobs_fd_pkg::cls_word_t              pop_word,
	output logic                                pop,
	input  logic [cobs_fd_pkg::LIMIT_WIDTH-1:0] max_out,
	cobs_fd_dec_if.source                       dec
);
	import cobs_fd_pkg::*;

	localparam int CMP_W = (COUNT_WIDTH > LIMIT_WIDTH) ? COUNT_WIDTH : LIMIT_WIDTH;

	logic [COUNT_WIDTH-1:0] cnt_q;
	err_t                   err_q;
	logic [COUNT_WIDTH-1:0] cnt_n;
	err_t                   err_n;
	logic                   emit;
	logic [CMP_W-1:0]       cnt_ext;
	logic [CMP_W-1:0]       cnt_n_ext;
	logic [CMP_W-1:0]       max_ext;

	logic                       out_valid_q;
	logic                       data_valid_q;
	logic [BYTE_WIDTH-1:0]      data_byte_q;
	logic                       frame_done_q;
	logic [OUT_COUNT_WIDTH-1:0] count_q;
	err_t                       error_q;

	assign pop     = !q_empty && (!out_valid_q || dec.ready);
	assign cnt_ext = CMP_W'(cnt_q);
	assign max_ext = CMP_W'(max_out);

	always_comb begin
		cnt_n = cnt_q;
		err_n = err_q;
		emit  = 1'b0;
		if (err_q == ERR_NONE) begin
			if (pop_word.want_emit) begin
				if (cnt_ext >= max_ext || cnt_q == '1) begin
					err_n = ERR_LIMIT;
				end else begin
					cnt_n = cnt_q + COUNT_WIDTH'(1);
					emit  = 1'b1;
				end
			end
			if (pop_word.last && err_n == ERR_NONE && pop_word.owed) begin
				err_n = ERR_TRUNC;
			end
		end
	end

	assign cnt_n_ext = CMP_W'(cnt_n);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q       <= '0;
			err_q       <= ERR_NONE;
			out_valid_q <= 1'b0;
		end else begin
			if (pop) begin
				out_valid_q <= 1'b1;
				if (pop_word.last) begin
					cnt_q <= '0;
					err_q <= ERR_NONE;
				end else begin
					cnt_q <= cnt_n;
					err_q <= err_n;
				end
			end else if (dec.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			data_valid_q <= emit;
			data_byte_q  <= emit ? pop_word.data : '0;
			frame_done_q <= pop_word.last;
			count_q      <= cnt_n_ext[OUT_COUNT_WIDTH-1:0];
			error_q      <= err_n;
		end
	end

	assign dec.valid         = out_valid_q;
	assign dec.data_valid    = data_valid_q;
	assign dec.data_byte     = data_byte_q;
	assign dec.frame_done    = frame_done_q;
	assign dec.decoded_count = count_q;
	assign dec.error_code    = error_q;

endmodule

FILE: sv/cobs_frame_decoder.sv
// cobs_frame_decoder: streaming cobs decoder top level, one result per encoded byte
// depends on cobs_fd_pkg, cobs_fd_if, cobs_fd_front, cobs_fd_queue, cobs_fd_back
//
// channel  role    word
// enc      sink    encoded_byte, frame_last
// dec      source  data_valid, data_byte, frame_done, decoded_count, error_code
// cfg      sink    max_output_bytes (always ready)
//
// one byte per cycle sustained while dec is ready; a byte's result word reaches dec in order
// (front classify into a two-entry queue, then count/limit into the result register)
// arst_n clears frame state, the queue and the result register; the limit resets to 65535
// a stalled dec fills the queue, then enc ready drops until the result is taken

module cobs_frame_decoder #(
	parameter int COUNT_WIDTH = cobs_fd_pkg::COUNT_WIDTH_DEF
) (
	input  logic          clk,
	input  logic          arst_n,
	cobs_fd_enc_if.sink   enc,
	cobs_fd_dec_if.source dec,
	cobs_fd_cfg_if.sink   cfg
);
	import cobs_fd_pkg::*;

	logic [LIMIT_WIDTH-1:0] max_out_q;
	logic                   push;
	logic                   pop;
	logic                   q_full;
	logic                   q_empty;
	cls_word_t              push_word;
	cls_word_t              pop_word;

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_out_q <= MAX_OUT_RESET;
		end else if (cfg.valid) begin
			max_out_q <= cfg.max_output_bytes;
		end
	end

	cobs_fd_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.enc       (enc),
		.q_full    (q_full),
		.push      (push),
		.push_word (push_word)
	);

	cobs_fd_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_word (push_word),
		.pop       (pop),
		.pop_word  (pop_word),
		.full      (q_full),
		.empty     (q_empty)
	);

	cobs_fd_back #(
		.COUNT_WIDTH (COUNT_WIDTH)
	) u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.q_empty  (q_empty),
		.pop_word (pop_word),
		.pop      (pop),
		.max_out  (max_out_q),
		.dec      (dec)
	);

endmodule

FILE: dv/cobs_frame_decoder_test.sv
// cobs_frame_decoder_test: self-checking bench for the streaming cobs frame decoder
// drives encoded frames under random idling, predicts every result word and checks them
// depends on cobs_fd_pkg, cobs_fd_if and the cobs_frame_decoder rtl

module cobs_frame_decoder_test;
	timeunit 1ns;
	timeprecision 1ps;

	import cobs_fd_pkg::*;

	localparam int CYCLE_LIMIT = 200000;

	typedef struct {
		logic [BYTE_WIDTH-1:0] value;
		logic                  last;
	} enc_word_t;

	typedef struct {
		logic                       data_valid;
		logic [BYTE_WIDTH-1:0]      data_byte;
		logic                       frame_done;
		logic [OUT_COUNT_WIDTH-1:0] decoded_count;
		err_t                       error_code;
	} decoded_word_t;

	typedef logic [BYTE_WIDTH-1:0] byte_q_t[$];

	logic clk;
	logic arst_n;

	cobs_fd_enc_if enc();
	cobs_fd_dec_if dec();
	cobs_fd_cfg_if cfg();

	cobs_frame_decoder DUT (
		.clk(clk),
		.arst_n(arst_n),
		.enc(enc),
		.dec(dec),
		.cfg(cfg)
	);

	enc_word_t     encoded_bytes[$];
	decoded_word_t pending_decoded[$];

	// decoder state as predicted
	logic [LIMIT_WIDTH-1:0]     limit_model;
	logic [BYTE_WIDTH-1:0]      blk_left;
	bit                         after_max;
	bit                         first_blk;
	logic [OUT_COUNT_WIDTH-1:0] out_count;
	err_t                       frame_err;

	int  failures;
	int  cycles;
	int  bytes_sent;
	int  frames_sent;
	int  words_checked;
	int  limits_used;
	int  send_wait;
	int  recv_wait;
	bit  send_calm;
	bit  recv_calm;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	function automatic void clear_frame();
		blk_left  = '0;
		after_max = 1'b0;
		first_blk = 1'b1;
		out_count = '0;
		frame_err = ERR_NONE;
	endfunction

	function automatic decoded_word_t decode_byte(input logic [BYTE_WIDTH-1:0] b,
		input logic last);
		decoded_word_t r;
		bit emit;
		logic [BYTE_WIDTH-1:0] val;
		r = '{1'b0, '0, 1'b0, '0, ERR_NONE};
		emit = 1'b0;
		val = '0;
		if (frame_err == ERR_NONE) begin
			if (blk_left == 0) begin
				emit = !first_blk && !after_max;
				first_blk = 1'b0;
				after_max = (b == CODE_MAX);
				blk_left = (b > CODE_ONE) ? b - 8'd1 : 8'd0;
			end else begin
				emit = 1'b1;
				val = b;
				blk_left = blk_left - 8'd1;
			end
			if (emit) begin
				if (out_count >= limit_model || out_count == '1) begin
					frame_err = ERR_LIMIT;
				end else begin
					out_count = out_count + OUT_COUNT_WIDTH'(1);
					r.data_valid = 1'b1;
					r.data_byte = val;
				end
			end
			if (last && frame_err == ERR_NONE && blk_left != 0) begin
				frame_err = ERR_TRUNC;
			end
		end
		r.frame_done = last;
		r.decoded_count = out_count;
		r.error_code = frame_err;
		if (last) begin
			clear_frame();
		end
		return r;
	endfunction

	function automatic int draw_gap(input bit calm);
		return calm ? 0 : $urandom_range(0, 6);
	endfunction

	function automatic void check_field(input string name, input logic [31:0] want,
		input logic [31:0] got);
		if (got !== want) begin
			$error("%s mismatch: expected %0h, got %0h", name, want, got);
			failures++;
		end
	endfunction

	// encoded side driver
	always @(posedge clk) begin
		enc_word_t w;
		if (arst_n) begin
			if (enc.valid && enc.ready) begin
				pending_decoded.push_back(decode_byte(enc.encoded_byte, enc.frame_last));
				bytes_sent++;
				if (enc.frame_last) begin
					frames_sent++;
				end
			end
			if (!enc.valid || enc.ready) begin
				if (send_wait > 0) begin
					send_wait--;
					enc.valid <= 1'b0;
				end else if (encoded_bytes.size() > 0) begin
					w = encoded_bytes.pop_front();
					enc.valid <= 1'b1;
					enc.encoded_byte <= w.value;
					enc.frame_last <= w.last;
					if ($urandom_range(0, 31) == 0) begin
						send_calm = !send_calm;
					end
					send_wait = draw_gap(send_calm);
				end else begin
					enc.valid <= 1'b0;
				end
			end
		end
	end

	// decoded side monitor
	always @(posedge clk) begin
		decoded_word_t e;
		if (arst_n) begin
			if (dec.valid && dec.ready) begin
				if (pending_decoded.size() == 0) begin
					$error("decoded word with no prediction waiting");
					failures++;
				end else begin
					e = pending_decoded.pop_front();
					check_field("data_valid", e.data_valid, dec.data_valid);
					check_field("data_byte", e.data_byte, dec.data_byte);
					check_field("frame_done", e.frame_done, dec.frame_done);
					check_field("decoded_count", e.decoded_count, dec.decoded_count);
					check_field("error_code", e.error_code, dec.error_code);
				end
				words_checked++;
				if ($urandom_range(0, 31) == 0) begin
					recv_calm = !recv_calm;
				end
				recv_wait = draw_gap(recv_calm);
			end else if (recv_wait > 0) begin
				recv_wait--;
			end
			dec.ready <= (recv_wait == 0);
		end
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("*** FAILED ***");
			$finish;
		end
	end

	task automatic push_frame(input byte_q_t b);
		foreach (b[i]) begin
			encoded_bytes.push_back('{b[i], i == b.size() - 1});
		end
	endtask

	task automatic add_random(input int n);
		int added;
		int kind;
		int cnt;
		int code;
		int cut;
		enc_word_t frm[$];
		added = 0;
		while (added < n) begin
			frm.delete();
			kind = $urandom_range(0, 9);
			if (kind < 9) begin
				cnt = $urandom_range(1, 4);
				for (int i = 0; i < cnt; i++) begin
					case ($urandom_range(0, 15))
						0: code = 0;
						1: code = 1;
						2, 3: code = $urandom_range(13, 40);
						default: code = $urandom_range(2, 12);
					endcase
					frm.push_back('{code[7:0], 1'b0});
					for (int j = 1; j < code; j++) begin
						frm.push_back('{8'($urandom), 1'b0});
					end
				end
				// broken frame: ends early, usually mid-block
				if (kind == 8) begin
					cut = $urandom_range(0, frm.size() - 1);
					while (frm.size() > cut + 1) begin
						void'(frm.pop_back());
					end
				end
			end else begin
				cnt = $urandom_range(1, 8);
				for (int i = 0; i < cnt; i++) begin
					frm.push_back('{8'($urandom), $urandom_range(0, 5) == 0});
				end
			end
			frm[frm.size() - 1].last = 1'b1;
			foreach (frm[i]) begin
				encoded_bytes.push_back(frm[i]);
			end
			added += frm.size();
		end
	endtask

	task automatic wait_drained();
		while (encoded_bytes.size() != 0 || enc.valid || pending_decoded.size() != 0) begin
			@(posedge clk);
		end
		repeat (4) @(posedge clk);
	endtask

	task automatic write_limit(input logic [LIMIT_WIDTH-1:0] value);
		@(posedge clk);
		cfg.valid <= 1'b1;
		cfg.max_output_bytes <= value;
		do begin
			@(posedge clk);
		end while (!cfg.ready);
		cfg.valid <= 1'b0;
		limit_model = value;
		limits_used++;
		@(negedge clk);
	endtask

	initial begin
		byte_q_t long_frm;
		arst_n = 1'b0;
		enc.valid = 1'b0;
		enc.encoded_byte = '0;
		enc.frame_last = 1'b0;
		dec.ready = 1'b1;
		cfg.valid = 1'b0;
		cfg.max_output_bytes = '0;
		failures = 0;
		cycles = 0;
		bytes_sent = 0;
		frames_sent = 0;
		words_checked = 0;
		limits_used = 1;
		send_wait = 0;
		recv_wait = 0;
		send_calm = 1'b0;
		recv_calm = 1'b0;
		limit_model = MAX_OUT_RESET;
		clear_frame();
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// reset limit: code zero, data extremes, restored zeros, truncation
		push_frame('{8'h00});
		push_frame('{8'h03, 8'h00, 8'hFF, 8'h01, 8'h02, 8'h80});
		push_frame('{8'h01, 8'h01, 8'h01});
		push_frame('{8'h04, 8'h12});
		push_frame('{8'h05});
		push_frame('{8'hFF, 8'h7E});
		add_random(60);
		wait_drained();

		// no output allowed
		write_limit('0);
		push_frame('{8'h02, 8'h33, 8'h01, 8'h44});
		push_frame('{8'h00});
		add_random(30);
		wait_drained();

		// one byte allowed: limit hit on data and on a restored zero
		write_limit(16'd1);
		push_frame('{8'h03, 8'hAA, 8'hBB, 8'h02});
		push_frame('{8'h02, 8'h5A, 8'h01});
		add_random(30);
		wait_drained();

		write_limit(16'($urandom_range(2, 12)));
		add_random(40);
		wait_drained();

		write_limit(16'($urandom_range(13, 60)));
		add_random(40);
		wait_drained();

		// full 255 block, no zero restored after it
		write_limit(MAX_OUT_RESET);
		long_frm.push_back(CODE_MAX);
		for (int i = 0; i < 254; i++) begin
			long_frm.push_back(8'($urandom));
		end
		long_frm.push_back(8'h03);
		long_frm.push_back(8'($urandom));
		long_frm.push_back(8'($urandom));
		long_frm.push_back(CODE_ONE);
		push_frame(long_frm);
		add_random(20);
		wait_drained();

		$display("%0d encoded bytes in %0d frames sent under %0d limit settings",
			bytes_sent, frames_sent, limits_used);
		$display("%0d decoded words compared, %0d mismatches", words_checked, failures);
		if (failures == 0) begin
			$display("*** PASSED ***");
		end else begin
			$display("*** FAILED ***");
		end
		$finish;
	end

endmodule

FILE: files.f
sv/cobs_fd_pkg.sv
sv/cobs_fd_if.sv
sv/cobs_fd_front.sv
sv/cobs_fd_queue.sv
sv/cobs_fd_back.sv
sv/cobs_frame_decoder.sv
dv/cobs_frame_decoder_test.sv
